// ----- design/erd_pkg.sv -----
// ============================================================================
// erd_pkg
// Shared types and constants of the energy region detector.
// ============================================================================
package erd_pkg;

    // Field widths
    localparam int ENERGY_W = 16;
    localparam int SAMPLE_W = 28;
    localparam int HOP_W    = 13;
    localparam int FRAME_W  = 14;
    localparam int CAP_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SAMPLE_W;

    // Defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF  = 65536;
    localparam int MAX_REGIONS_DEF = 64;

    // Register reset values
    localparam logic [ENERGY_W-1:0] THRESHOLD_RST = '0;
    localparam logic [HOP_W-1:0]    HOP_RST       = HOP_W'(256);
    localparam logic [FRAME_W-1:0]  FRAME_RST     = FRAME_W'(1024);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = '1;
    localparam logic [CAP_W-1:0]    CAP_RST       = CAP_W'(64);

    // Result queue: holds the worst case of every frame in flight
    localparam int RESULTS_PER_FRAME = 3;
    localparam int FIFO_DEPTH        = 16;
    localparam int FIFO_AW           = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW           = $clog2(FIFO_DEPTH + 1);

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_HOP        = 3'd1,
        CFG_FRAME      = 3'd2,
        CFG_MERGE_GAP  = 3'd3,
        CFG_MIN_DUR    = 3'd4,
        CFG_PAD        = 3'd5,
        CFG_AUDIO_LEN  = 3'd6,
        CFG_CAPACITY   = 3'd7
    } t_cfg_reg;

    // One result beat
    typedef struct packed {
        logic                has_region;
        logic [SAMPLE_W-1:0] start_sample;
        logic [SAMPLE_W-1:0] end_sample;
        logic                is_last;
    } t_result;

endpackage

// ----- design/erd_in_if.sv -----
// ============================================================================
// erd_in_if
// Frame energy channel: one beat per frame.
// ============================================================================
interface erd_in_if;
    import erd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic                last_frame;

    modport source (output valid, output energy, output last_frame, input ready);
    modport sink   (input valid, input energy, input last_frame, output ready);

endinterface

// ----- design/erd_out_if.sv -----
// ============================================================================
// erd_out_if
// Region result channel: regions and the end-of-clip marker.
// ============================================================================
interface erd_out_if;
    import erd_pkg::*;

    logic                valid;
    logic                ready;
    logic                has_region;
    logic [SAMPLE_W-1:0] start_sample;
    logic [SAMPLE_W-1:0] end_sample;
    logic                is_last;

    modport source (output valid, output has_region, output start_sample,
                    output end_sample, output is_last, input ready);
    modport sink   (input valid, input has_region, input start_sample,
                    input end_sample, input is_last, output ready);

endinterface

// ----- design/energy_region_detector_unit.sv -----
// ============================================================================
// energy_region_detector_unit
// Energy-threshold segmentation of a frame stream into padded sample regions.
// ============================================================================
// One energy beat per frame enters; a frame at or above the threshold is
// active, and a run of active frames becomes a region in samples
// (first frame * hop .. last frame * hop + frame_samples, saturated to 28 bits).
// Regions are merged across gaps up to merge_gap, filtered by min_duration,
// padded and clamped to 0..audio_length. A frame with last_frame set closes
// the open run, flushes the held region and is followed by an end-of-clip
// marker (has_region 0, is_last 1). The block takes one frame per clock
// cycle while input ready is high. Work runs in four steps: run tracking
// at the input beat, the two frame-to-sample products, the merge against
// the held region, then duration filter and padding into a 16-entry
// result queue. A region passes the step A, B and C registers before it
// enters the queue. A frame can cause up to three results, so input ready
// drops while the queue cannot absorb three results for every frame still
// in flight; the output side drains one beat per cycle while the receiver
// is ready. Configuration writes take effect at once and belong in idle
// time between clips; region_capacity is bounded by MAX_REGIONS.
// ============================================================================
module energy_region_detector_unit #(
    parameter int MAX_FRAMES  = erd_pkg::MAX_FRAMES_DEF,
    parameter int MAX_REGIONS = erd_pkg::MAX_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    erd_in_if.sink                        i_in,
    erd_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [erd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [erd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import erd_pkg::*;

    localparam int FW = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = $clog2(MAX_REGIONS + 1);
    localparam int PW = FW + HOP_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ENERGY_W-1:0] r_threshold;
    logic [HOP_W-1:0]    r_hop;
    logic [FRAME_W-1:0]  r_frame;
    logic [SAMPLE_W-1:0] r_merge_gap;
    logic [SAMPLE_W-1:0] r_min_dur;
    logic [SAMPLE_W-1:0] r_pad;
    logic [SAMPLE_W-1:0] r_audio_len;
    logic [CAP_W-1:0]    r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_hop       <= HOP_RST;
            r_frame     <= FRAME_RST;
            r_merge_gap <= '0;
            r_min_dur   <= '0;
            r_pad       <= '0;
            r_audio_len <= SAMPLE_MAX;
            r_capacity  <= CAP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[ENERGY_W-1:0];
                CFG_HOP:       r_hop       <= i_cfg_wdata[HOP_W-1:0];
                CFG_FRAME:     r_frame     <= i_cfg_wdata[FRAME_W-1:0];
                CFG_MERGE_GAP: r_merge_gap <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_MIN_DUR:   r_min_dur   <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_PAD:       r_pad       <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_AUDIO_LEN: r_audio_len <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_CAPACITY:  r_capacity  <= i_cfg_wdata[CAP_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: reserve queue room for every frame in flight
    // ------------------------------------------------------------------
    logic               r_a_valid, r_b_valid, r_c_valid;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_CW+1:0] w_reserve;
    logic               w_accept;

    assign w_reserve = (FIFO_CW+2)'(r_count)
                     + (FIFO_CW+2)'(RESULTS_PER_FRAME)
                       * (FIFO_CW+2)'({2'b00, r_a_valid} + {2'b00, r_b_valid}
                                      + {2'b00, r_c_valid} + 3'd1);
    assign i_in.ready = (w_reserve <= (FIFO_CW+2)'(FIFO_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Step A: run tracking at the input beat
    // ------------------------------------------------------------------
    logic          r_in_run;
    logic [FW-1:0] r_frame_idx;
    logic [FW-1:0] r_run_start;
    logic [RW-1:0] r_region_cnt;

    logic          w_active, w_start_now, w_close_idle, w_close, w_take, w_last;
    logic [FW-1:0] w_sf, w_ef_raw, w_ef;
    logic [CAP_W-1:0] w_cap;

    assign w_last       = i_in.last_frame;
    assign w_active     = (i_in.energy >= r_threshold);
    assign w_start_now  = w_active && !r_in_run;
    assign w_sf         = w_start_now ? r_frame_idx : r_run_start;
    assign w_close_idle = !w_active && r_in_run;
    assign w_close      = w_close_idle || (w_last && (r_in_run || w_active));
    // A run closed by an idle frame ends on the frame before it
    assign w_ef_raw     = w_close_idle
                        ? ((r_frame_idx != '0) ? r_frame_idx - 1'b1 : '0)
                        : r_frame_idx;
    // After index saturation the end may fall before the start
    assign w_ef         = (w_ef_raw < w_sf) ? w_sf : w_ef_raw;
    assign w_cap        = (r_capacity < CAP_W'(MAX_REGIONS))
                        ? r_capacity : CAP_W'(MAX_REGIONS);
    assign w_take       = w_close && (CAP_W'(r_region_cnt) < w_cap);

    logic          r_a_take, r_a_last;
    logic [FW-1:0] r_a_sf, r_a_ef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_frame_idx  <= '0;
            r_run_start  <= '0;
            r_region_cnt <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            // Only beats that close a region or end the clip go further
            r_a_valid <= w_accept && (w_take || w_last);
            if (w_accept) begin
                if (w_last) begin
                    r_in_run     <= 1'b0;
                    r_frame_idx  <= '0;
                    r_run_start  <= '0;
                    r_region_cnt <= '0;
                end else begin
                    r_in_run <= w_active;
                    if (w_start_now) begin
                        r_run_start <= r_frame_idx;
                    end
                    if (r_frame_idx != FW'(MAX_FRAMES - 1)) begin
                        r_frame_idx <= r_frame_idx + 1'b1;
                    end
                    if (w_take) begin
                        r_region_cnt <= r_region_cnt + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_take <= w_take;
        r_a_last <= w_last;
        r_a_sf   <= w_sf;
        r_a_ef   <= w_ef;
    end

    // ------------------------------------------------------------------
    // Step B: frame numbers to samples, saturated to 28 bits
    // ------------------------------------------------------------------
    logic [PW-1:0]         w_prod_s, w_prod_e;
    logic [SAMPLE_W+1:0]   w_rs_sum, w_re_sum;
    logic [SAMPLE_W-1:0]   w_rs, w_re;

    assign w_prod_s = PW'(r_a_sf) * PW'(r_hop);
    assign w_prod_e = PW'(r_a_ef) * PW'(r_hop);
    assign w_rs_sum = (SAMPLE_W+2)'(w_prod_s);
    assign w_re_sum = (SAMPLE_W+2)'(w_prod_e) + (SAMPLE_W+2)'(r_frame);
    assign w_rs     = (|w_rs_sum[SAMPLE_W+1:SAMPLE_W]) ? SAMPLE_MAX
                                                        : w_rs_sum[SAMPLE_W-1:0];
    assign w_re     = (|w_re_sum[SAMPLE_W+1:SAMPLE_W]) ? SAMPLE_MAX
                                                        : w_re_sum[SAMPLE_W-1:0];

    logic                r_b_take, r_b_last;
    logic [SAMPLE_W-1:0] r_b_rs, r_b_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_take <= r_a_take;
        r_b_last <= r_a_last;
        r_b_rs   <= w_rs;
        r_b_re   <= w_re;
    end

    // ------------------------------------------------------------------
    // Step C: merge with the held region
    // ------------------------------------------------------------------
    logic                r_held_valid;
    logic [SAMPLE_W-1:0] r_held_start, r_held_end;

    logic                w_merge, w_rel0, w_rel1, n_held_valid;
    logic [SAMPLE_W-1:0] n_held_start, n_held_end;

    assign w_merge = ({1'b0, r_b_rs} <= ({1'b0, r_held_end} + {1'b0, r_merge_gap}));
    assign w_rel0  = r_b_take && r_held_valid && !w_merge;

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_start = r_held_start;
        n_held_end   = r_held_end;
        if (r_b_take) begin
            n_held_valid = 1'b1;
            if (r_held_valid && w_merge) begin
                if (r_b_re > r_held_end) begin
                    n_held_end = r_b_re;
                end
            end else begin
                n_held_start = r_b_rs;
                n_held_end   = r_b_re;
            end
        end
    end

    // End of clip flushes whatever is held after the merge
    assign w_rel1 = r_b_last && n_held_valid;

    logic                r_c_rel0, r_c_rel1, r_c_mark;
    logic [SAMPLE_W-1:0] r_c_s0, r_c_e0, r_c_s1, r_c_e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_c_valid    <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
            if (r_b_valid) begin
                r_held_valid <= n_held_valid && !r_b_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_held_start <= n_held_start;
            r_held_end   <= n_held_end;
        end
        r_c_rel0 <= w_rel0;
        r_c_rel1 <= w_rel1;
        r_c_mark <= r_b_last;
        r_c_s0   <= r_held_start;
        r_c_e0   <= r_held_end;
        r_c_s1   <= n_held_start;
        r_c_e1   <= n_held_end;
    end

    // ------------------------------------------------------------------
    // Step D: duration filter, padding and clamp, then queue up
    // ------------------------------------------------------------------
    function automatic logic f_keep(input logic [SAMPLE_W-1:0] s,
                                    input logic [SAMPLE_W-1:0] e,
                                    input logic [SAMPLE_W-1:0] min_dur);
        logic [SAMPLE_W-1:0] dur;
        dur = (e >= s) ? e - s : '0;
        return dur >= min_dur;
    endfunction

    function automatic t_result f_pad(input logic [SAMPLE_W-1:0] s,
                                      input logic [SAMPLE_W-1:0] e,
                                      input logic [SAMPLE_W-1:0] pad,
                                      input logic [SAMPLE_W-1:0] audio);
        logic [SAMPLE_W:0] ep;
        t_result           res;
        ep               = {1'b0, e} + {1'b0, pad};
        res.has_region   = 1'b1;
        res.start_sample = (s > pad) ? s - pad : '0;
        res.end_sample   = (ep > {1'b0, audio}) ? audio : ep[SAMPLE_W-1:0];
        res.is_last      = 1'b0;
        return res;
    endfunction

    logic    w_push0, w_push1, w_push2, w_pop;
    t_result w_res0, w_res1, w_mark;
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr, w_p1, w_p2;
    logic [1:0]         w_npush;

    assign w_push0 = r_c_valid && r_c_rel0 && f_keep(r_c_s0, r_c_e0, r_min_dur);
    assign w_push1 = r_c_valid && r_c_rel1 && f_keep(r_c_s1, r_c_e1, r_min_dur);
    assign w_push2 = r_c_valid && r_c_mark;
    assign w_res0  = f_pad(r_c_s0, r_c_e0, r_pad, r_audio_len);
    assign w_res1  = f_pad(r_c_s1, r_c_e1, r_pad, r_audio_len);
    assign w_mark  = '{has_region: 1'b0, start_sample: '0, end_sample: '0, is_last: 1'b1};

    // Pack the results in order: released region, flushed region, marker
    assign w_p1    = r_wr_ptr + FIFO_AW'(w_push0);
    assign w_p2    = w_p1 + FIFO_AW'(w_push1);
    assign w_npush = 2'(w_push0) + 2'(w_push1) + 2'(w_push2);
    assign w_pop   = o_out.valid && o_out.ready;

    t_result r_fifo [FIFO_DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_push0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_push1) begin
            r_fifo[w_p1] <= w_res1;
        end
        if (w_push2) begin
            r_fifo[w_p2] <= w_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_npush);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CW'(w_npush) - FIFO_CW'(w_pop);
        end
    end

    // ------------------------------------------------------------------
    // Output beat straight from the queue head
    // ------------------------------------------------------------------
    t_result w_head;

    assign w_head             = r_fifo[r_rd_ptr];
    assign o_out.valid        = (r_count != '0);
    assign o_out.has_region   = w_head.has_region;
    assign o_out.start_sample = w_head.start_sample;
    assign o_out.end_sample   = w_head.end_sample;
    assign o_out.is_last      = w_head.is_last;

`ifndef SYNTH
    // Queue never overflows: reservation covers all frames in flight
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A last frame restarts the clip state
    a_clip_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_frame_idx == '0 && r_region_cnt == '0 && !r_in_run))
        else $error("clip state not cleared after last frame");

    // Held region is dropped once the clip end passes the merge step
    a_held_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_last) |=> !r_held_valid)
        else $error("held region survives clip end");

    // Raw region count stays within the capacity bound
    a_raw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_region_cnt) <= CAP_W'(MAX_REGIONS))
        else $error("raw region count beyond capacity");

    // Every output beat is either a region or the end marker
    a_beat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.has_region != o_out.is_last))
        else $error("malformed result beat");
`endif

endmodule
